>>> src/lacm_pkg.sv
package lacm_pkg;

    // Block geometry.
    localparam int LAG        = 64;
    localparam int WINDOW     = 128;
    localparam int HIST_DEPTH = LAG + WINDOW;
    localparam int FILL_EMIT  = LAG + WINDOW - 1;

    // Field and accumulator widths.
    localparam int SAMPLE_W = 16;
    localparam int PAIR_W   = 2 * SAMPLE_W;
    localparam int PROD_W   = 33;
    localparam int POWER_W  = 32;
    localparam int CORR_W   = 40;
    localparam int ENERGY_W = 39;
    localparam int START_W  = 32;
    localparam int METRIC_W = 16;

    // Ring pointer and fill counter widths.
    localparam int DPOS_W = (LAG > 1) ? $clog2(LAG) : 1;
    localparam int PPOS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int HPOS_W = $clog2(HIST_DEPTH);
    localparam int CNT_W  = $clog2(HIST_DEPTH + 1);

    // Shared multiplier: signed operands, 20-bit halves of the wide values.
    localparam int HALF_W  = 20;
    localparam int MUL_W   = HALF_W + 1;
    localparam int SH_W    = 7;
    localparam int NUM_W   = 80;
    localparam int DEN_W   = 78;
    localparam int NUM_SH  = 2 * (METRIC_W - 1);
    localparam int ROOT_W  = 112;
    localparam int OP_W    = 4;
    localparam int BIT_W   = $clog2(METRIC_W);

    // Micro-operation numbers.
    localparam logic [OP_W-1:0] OP_SAMPLE_LAST = OP_W'(5);
    localparam logic [OP_W-1:0] OP_METRIC_FIRST = OP_W'(6);
    localparam logic [OP_W-1:0] OP_METRIC_LAST = OP_W'(15);

endpackage

>>> src/lacm_if.sv
interface lacm_smp_if;
    import lacm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    modport source (output valid, first, sample_re, sample_im, input ready);
    modport sink (input valid, first, sample_re, sample_im, output ready);
endinterface

interface lacm_res_if;
    import lacm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [START_W-1:0]       window_start;
    logic [METRIC_W-1:0]      metric;
    logic signed [CORR_W-1:0] corr_re;
    logic signed [CORR_W-1:0] corr_im;
    modport source (output valid, window_start, metric, corr_re, corr_im, input ready);
    modport sink (input valid, window_start, metric, corr_re, corr_im, output ready);
endinterface

interface lacm_cfg_if;
    import lacm_pkg::*;
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> src/lacm_ram.sv
module lacm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/lag_autocorr_timing_metric.sv
// Channel   Direction  Transaction contents
// i_smp     in         first, sample_re, sample_im
// o_res     out        window_start, metric, corr_re, corr_im
// i_cfg     in         energy_floor write data
//
// A sample that gives a result takes longer than one that does not;
// one shared 21x21 multiplier and a bit-serial root loop (16 steps) set this.
// Reset is synchronous and active low and clears the window sums and the fill count.
// A finished result waits in the output register while the next sample is taken;
// the sequencer holds only if a new result is ready and the old one is not taken.
module lag_autocorr_timing_metric
    import lacm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lacm_smp_if.sink    i_smp,
    lacm_res_if.source  o_res,
    lacm_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RB, S_RC, S_RD, S_MS, S_MSD, S_UPD,
        S_MM, S_MMD, S_RINIT, S_ROOT, S_FIN
    } t_state;

    typedef enum logic [2:0] {ACC_PRE, ACC_PIM, ACC_PW, ACC_NUM, ACC_DEN} t_acc;

    t_state r_state;

    // Configuration and running state.
    logic [ENERGY_W-1:0]      r_floor;
    logic signed [CORR_W-1:0] r_corr_re, r_corr_im;
    logic [ENERGY_W-1:0]      r_early, r_late;
    logic [CNT_W-1:0]         r_cnt;
    logic [START_W-1:0]       r_start;
    logic [DPOS_W-1:0]        r_dpos;
    logic [PPOS_W-1:0]        r_ppos;
    logic [HPOS_W-1:0]        r_hpos;

    // Current sample and values read from the rings.
    logic signed [SAMPLE_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [PROD_W-1:0]   r_old_pre, r_old_pim;
    logic [POWER_W-1:0]         r_h_late, r_h_add, r_h_old;

    // Multiplier pipeline and accumulators.
    logic [OP_W-1:0]              r_op;
    logic signed [2*MUL_W-1:0]    r_prod;
    logic                         r_pv;
    t_acc                         r_acc;
    logic                         r_neg;
    logic [SH_W-1:0]              r_sh;
    logic signed [PROD_W-1:0]     r_pre, r_pim;
    logic [POWER_W-1:0]           r_pw;
    logic [NUM_W-1:0]             r_num;
    logic [DEN_W-1:0]             r_den;

    // Root search registers.
    logic [ROOT_W-1:0]   r_p, r_t, r_d2;
    logic [BIT_W-1:0]    r_k;
    logic [METRIC_W-1:0] r_m;

    // Output register.
    logic                     r_out_valid;
    logic [START_W-1:0]       r_out_start;
    logic [METRIC_W-1:0]      r_out_metric;
    logic signed [CORR_W-1:0] r_out_re, r_out_im;

    // Memory ports.
    logic [PAIR_W-1:0]   dly_rdata;
    logic [2*PROD_W-1:0] prd_rdata;
    logic [POWER_W-1:0]  hst_rdata;
    logic [HPOS_W-1:0]   hst_raddr;
    logic                ram_we;

    lacm_ram #(.WIDTH(PAIR_W), .DEPTH(LAG)) u_delay (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dpos),
        .i_wdata ({r_b, r_a}),
        .i_raddr (r_dpos),
        .o_rdata (dly_rdata)
    );

    lacm_ram #(.WIDTH(2 * PROD_W), .DEPTH(WINDOW)) u_prod (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ppos),
        .i_wdata ({r_pim, r_pre}),
        .i_raddr (r_ppos),
        .o_rdata (prd_rdata)
    );

    lacm_ram #(.WIDTH(POWER_W), .DEPTH(HIST_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_hpos),
        .i_wdata (r_pw),
        .i_raddr (hst_raddr),
        .o_rdata (hst_rdata)
    );

    assign ram_we = (r_state == S_UPD);

    // History addresses LAG and WINDOW entries ahead of the write position.
    logic [HPOS_W:0] h_late_x, h_add_x;
    logic [HPOS_W-1:0] h_late, h_add;

    always_comb begin
        h_late_x = {1'b0, r_hpos} + (HPOS_W + 1)'(LAG);
        h_add_x  = {1'b0, r_hpos} + (HPOS_W + 1)'(WINDOW);
        h_late   = (h_late_x >= (HPOS_W + 1)'(HIST_DEPTH)) ?
                   HPOS_W'(h_late_x - (HPOS_W + 1)'(HIST_DEPTH)) : HPOS_W'(h_late_x);
        h_add    = (h_add_x >= (HPOS_W + 1)'(HIST_DEPTH)) ?
                   HPOS_W'(h_add_x - (HPOS_W + 1)'(HIST_DEPTH)) : HPOS_W'(h_add_x);
    end

    always_comb begin
        unique case (r_state)
            S_RB:    hst_raddr = h_add;
            S_RC:    hst_raddr = r_hpos;
            default: hst_raddr = h_late;
        endcase
    end

    // Magnitudes of the correlation and floored energies for the metric.
    logic [CORR_W-1:0] mag_re, mag_im, e1, e2;

    always_comb begin
        mag_re = r_corr_re[CORR_W-1] ? (~r_corr_re + CORR_W'(1)) : r_corr_re;
        mag_im = r_corr_im[CORR_W-1] ? (~r_corr_im + CORR_W'(1)) : r_corr_im;
        e1 = {1'b0, (r_early > r_floor) ? r_early : r_floor};
        e2 = {1'b0, (r_late > r_floor) ? r_late : r_floor};
    end

    // Micro-operation decode for the shared multiplier.
    logic signed [MUL_W-1:0] op_a, op_b;
    logic signed [MUL_W-1:0] sa, sb, sc, sd;
    t_acc                    op_acc;
    logic                    op_neg;
    logic [SH_W-1:0]         op_sh;

    assign sa = {{(MUL_W - SAMPLE_W){r_a[SAMPLE_W-1]}}, r_a};
    assign sb = {{(MUL_W - SAMPLE_W){r_b[SAMPLE_W-1]}}, r_b};
    assign sc = {{(MUL_W - SAMPLE_W){r_c[SAMPLE_W-1]}}, r_c};
    assign sd = {{(MUL_W - SAMPLE_W){r_d[SAMPLE_W-1]}}, r_d};

    always_comb begin
        op_neg = 1'b0;
        op_sh  = '0;
        unique case (r_op)
            4'd0:  begin op_a = sa; op_b = sc; op_acc = ACC_PRE; end
            4'd1:  begin op_a = sb; op_b = sd; op_acc = ACC_PRE; end
            4'd2:  begin op_a = sb; op_b = sc; op_acc = ACC_PIM; end
            4'd3:  begin op_a = sa; op_b = sd; op_acc = ACC_PIM; op_neg = 1'b1; end
            4'd4:  begin op_a = sa; op_b = sa; op_acc = ACC_PW; end
            4'd5:  begin op_a = sb; op_b = sb; op_acc = ACC_PW; end
            4'd6:  begin
                op_a = {1'b0, mag_re[HALF_W-1:0]}; op_b = {1'b0, mag_re[HALF_W-1:0]};
                op_acc = ACC_NUM;
            end
            4'd7:  begin
                op_a = {1'b0, mag_re[CORR_W-1:HALF_W]}; op_b = {1'b0, mag_re[HALF_W-1:0]};
                op_acc = ACC_NUM; op_sh = SH_W'(HALF_W + 1);
            end
            4'd8:  begin
                op_a = {1'b0, mag_re[CORR_W-1:HALF_W]}; op_b = {1'b0, mag_re[CORR_W-1:HALF_W]};
                op_acc = ACC_NUM; op_sh = SH_W'(2 * HALF_W);
            end
            4'd9:  begin
                op_a = {1'b0, mag_im[HALF_W-1:0]}; op_b = {1'b0, mag_im[HALF_W-1:0]};
                op_acc = ACC_NUM;
            end
            4'd10: begin
                op_a = {1'b0, mag_im[CORR_W-1:HALF_W]}; op_b = {1'b0, mag_im[HALF_W-1:0]};
                op_acc = ACC_NUM; op_sh = SH_W'(HALF_W + 1);
            end
            4'd11: begin
                op_a = {1'b0, mag_im[CORR_W-1:HALF_W]}; op_b = {1'b0, mag_im[CORR_W-1:HALF_W]};
                op_acc = ACC_NUM; op_sh = SH_W'(2 * HALF_W);
            end
            4'd12: begin
                op_a = {1'b0, e1[HALF_W-1:0]}; op_b = {1'b0, e2[HALF_W-1:0]};
                op_acc = ACC_DEN;
            end
            4'd13: begin
                op_a = {1'b0, e1[HALF_W-1:0]}; op_b = {1'b0, e2[CORR_W-1:HALF_W]};
                op_acc = ACC_DEN; op_sh = SH_W'(HALF_W);
            end
            4'd14: begin
                op_a = {1'b0, e1[CORR_W-1:HALF_W]}; op_b = {1'b0, e2[HALF_W-1:0]};
                op_acc = ACC_DEN; op_sh = SH_W'(HALF_W);
            end
            default: begin
                op_a = {1'b0, e1[CORR_W-1:HALF_W]}; op_b = {1'b0, e2[CORR_W-1:HALF_W]};
                op_acc = ACC_DEN; op_sh = SH_W'(2 * HALF_W);
            end
        endcase
    end

    logic signed [2*MUL_W-1:0] mul_p;
    assign mul_p = op_a * op_b;

    // Window sum updates.
    logic signed [CORR_W-1:0] n_corr_re, n_corr_im;
    logic [ENERGY_W-1:0]      n_late, n_early;

    always_comb begin
        n_corr_re = r_corr_re + {{(CORR_W - PROD_W){r_pre[PROD_W-1]}}, r_pre}
                  - {{(CORR_W - PROD_W){r_old_pre[PROD_W-1]}}, r_old_pre};
        n_corr_im = r_corr_im + {{(CORR_W - PROD_W){r_pim[PROD_W-1]}}, r_pim}
                  - {{(CORR_W - PROD_W){r_old_pim[PROD_W-1]}}, r_old_pim};
        n_late    = r_late + ENERGY_W'(r_pw) - ENERGY_W'(r_h_late);
        n_early   = r_early + ENERGY_W'(r_h_add) - ENERGY_W'(r_h_old);
    end

    // One step of the bit-serial root: try setting bit k of the metric.
    logic [ROOT_W-1:0] cand, num_full;

    assign cand     = r_p + r_t + r_d2;
    assign num_full = ROOT_W'({r_num, {NUM_SH{1'b0}}});

    logic emit;
    assign emit = (r_cnt >= CNT_W'(FILL_EMIT));

    // A finished result moves into the output register once that is free.
    logic out_load;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    // Sequencer, accumulators and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_floor     <= '0;
            r_corr_re   <= '0;
            r_corr_im   <= '0;
            r_early     <= '0;
            r_late      <= '0;
            r_cnt       <= '0;
            r_start     <= '0;
            r_dpos      <= '0;
            r_ppos      <= '0;
            r_hpos      <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_floor <= i_cfg.data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // Multiplier stage, with accumulation in the next cycle.
            r_pv   <= (r_state == S_MS) || (r_state == S_MM);
            r_prod <= mul_p;
            r_acc  <= op_acc;
            r_neg  <= op_neg;
            r_sh   <= op_sh;
            if (r_pv) begin
                unique case (r_acc)
                    ACC_PRE: r_pre <= r_pre + PROD_W'(r_prod);
                    ACC_PIM: r_pim <= r_neg ? r_pim - PROD_W'(r_prod) : r_pim + PROD_W'(r_prod);
                    ACC_PW:  r_pw  <= r_pw + POWER_W'(r_prod);
                    ACC_NUM: r_num <= r_num + (NUM_W'(r_prod[2*HALF_W-1:0]) << r_sh);
                    default: r_den <= r_den + (DEN_W'(r_prod[2*HALF_W-1:0]) << r_sh);
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_a   <= i_smp.sample_re;
                        r_b   <= i_smp.sample_im;
                        r_pre <= '0;
                        r_pim <= '0;
                        r_pw  <= '0;
                        if (i_smp.first) begin
                            r_corr_re <= '0;
                            r_corr_im <= '0;
                            r_early   <= '0;
                            r_late    <= '0;
                            r_cnt     <= '0;
                            r_start   <= '0;
                        end
                        r_state <= S_RA;
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: begin
                    // Entries not yet written since the last clear read as zero.
                    if (r_cnt >= CNT_W'(LAG)) begin
                        r_c <= dly_rdata[SAMPLE_W-1:0];
                        r_d <= dly_rdata[PAIR_W-1:SAMPLE_W];
                    end else begin
                        r_c <= '0;
                        r_d <= '0;
                    end
                    if (r_cnt >= CNT_W'(WINDOW)) begin
                        r_old_pre <= prd_rdata[PROD_W-1:0];
                        r_old_pim <= prd_rdata[2*PROD_W-1:PROD_W];
                        r_h_late  <= hst_rdata;
                    end else begin
                        r_old_pre <= '0;
                        r_old_pim <= '0;
                        r_h_late  <= '0;
                    end
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_h_add <= (r_cnt >= CNT_W'(LAG)) ? hst_rdata : '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_h_old <= (r_cnt >= CNT_W'(HIST_DEPTH)) ? hst_rdata : '0;
                    r_op    <= '0;
                    r_state <= S_MS;
                end
                S_MS: begin
                    r_op <= r_op + OP_W'(1);
                    if (r_op == OP_SAMPLE_LAST) begin
                        r_state <= S_MSD;
                    end
                end
                S_MSD: r_state <= S_UPD;
                S_UPD: begin
                    r_corr_re <= n_corr_re;
                    r_corr_im <= n_corr_im;
                    r_late    <= n_late;
                    r_early   <= n_early;
                    r_dpos    <= (r_dpos == DPOS_W'(LAG - 1)) ? '0 : r_dpos + DPOS_W'(1);
                    r_ppos    <= (r_ppos == PPOS_W'(WINDOW - 1)) ? '0 : r_ppos + PPOS_W'(1);
                    r_hpos    <= (r_hpos == HPOS_W'(HIST_DEPTH - 1)) ? '0 : r_hpos + HPOS_W'(1);
                    if (r_cnt < CNT_W'(HIST_DEPTH)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_num <= '0;
                    r_den <= '0;
                    r_op  <= OP_METRIC_FIRST;
                    r_state <= emit ? S_MM : S_IDLE;
                end
                S_MM: begin
                    r_op <= r_op + OP_W'(1);
                    if (r_op == OP_METRIC_LAST) begin
                        r_state <= S_MMD;
                    end
                end
                S_MMD: r_state <= S_RINIT;
                S_RINIT: begin
                    r_p     <= '0;
                    r_t     <= '0;
                    r_d2    <= ROOT_W'(r_den) << NUM_SH;
                    r_k     <= BIT_W'(METRIC_W - 1);
                    r_m     <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (cand <= num_full) begin
                        r_p <= cand;
                        r_t <= (r_t >> 1) + r_d2;
                        r_m <= r_m | (METRIC_W'(1) << r_k);
                    end else begin
                        r_t <= r_t >> 1;
                    end
                    r_d2 <= r_d2 >> 2;
                    r_k  <= r_k - BIT_W'(1);
                    if (r_k == '0) begin
                        r_state <= S_FIN;
                    end
                end
                default: begin
                    // Hand the result over once the output register is free.
                    if (out_load) begin
                        r_out_start  <= r_start;
                        r_out_metric <= (r_den == '0) ? '0 : r_m;
                        r_out_re     <= r_corr_re;
                        r_out_im     <= r_corr_im;
                        r_start      <= r_start + START_W'(1);
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_smp.ready        = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_out_valid;
    assign o_res.window_start = r_out_start;
    assign o_res.metric       = r_out_metric;
    assign o_res.corr_re      = r_out_re;
    assign o_res.corr_im      = r_out_im;

endmodule
